/* design/vst_pkg.sv */
package vst_pkg;

  typedef enum logic [1:0] {
    REQ_BUMP   = 2'd0,
    REQ_ASSIGN = 2'd1,
    REQ_PICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    REG_VAR_COUNT    = 2'd0,
    REG_DECAY_FACTOR = 2'd1,
    REG_BUMP_GROWTH  = 2'd2,
    REG_DECAY_PERIOD = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUMP_RD,
    ST_BUMP_WR,
    ST_GROW_LO,
    ST_GROW_HI,
    ST_GROW_SUM,
    ST_DEC_RD,
    ST_DEC_LO,
    ST_DEC_HI,
    ST_DEC_WR,
    ST_PICK_RD,
    ST_PICK_CMP,
    ST_OUT
  } state_e;

  localparam int LitW    = 12;
  localparam int VarW    = 11;
  localparam int FactorW = 16;
  localparam int GrowW   = 17;
  localparam int PeriodW = 10;
  localparam int FracW   = 16;

  typedef struct packed {
    logic [1:0]           req_type;
    logic signed [LitW-1:0] literal;
    logic                 clause_end;
    logic [VarW-1:0]      variable;
    logic                 is_assigned;
  } req_t;

  typedef struct packed {
    logic signed [LitW-1:0] chosen_literal;
    logic                   found;
  } rsp_t;

endpackage

/* design/vst_if.sv */
interface vst_req_if;
  import vst_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vst_rsp_if;
  import vst_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/vst_mul.sv */
// Shared multiplier: 32 x 17 partial product, registered.
module vst_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [16:0] b_i,
  output logic [48:0] p_o
);
  logic [48:0] p_q;
  always_ff @(posedge clk_i) begin
    p_q <= {17'd0, a_i} * {32'd0, b_i};
  end
  assign p_o = p_q;
endmodule

/* design/vsids_score_table.sv */
// Channel  | Dir | Word
// req      | in  | req_type, literal, clause_end, variable, is_assigned
// rsp      | out | chosen_literal, found (pick only)
// cfg      | in  | APB registers var_count, decay_factor, bump_growth, decay_period
//
// After reset a clearing pass writes every score entry and every assignment flag
// to zero, one row at a time, during which no word is accepted. A bump reads the
// score row and writes it back, then on a clause end computes the bump growth, and
// when that clause end triggers a decay rescales every row (one shared multiplier,
// two half-products per score, both scores of a row written back together). An
// assignment is written on acceptance. A pick scans the variables in turn through
// the single score memory port, then holds the result until taken; the block waits.
module vsids_score_table #(
  parameter int NUM_VARS   = 1024,
  parameter int SCORE_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vst_req_if.sink     req,
  vst_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vst_pkg::*;

  localparam int AW = $clog2(NUM_VARS);
  localparam int CW = $clog2(NUM_VARS + 1);
  localparam logic [SCORE_BITS-1:0] SMax = {SCORE_BITS{1'b1}};

  // Configuration registers.
  logic [VarW-1:0]    var_count_q;
  logic [FactorW-1:0] decay_factor_q;
  logic [GrowW-1:0]   bump_growth_q;
  logic [PeriodW-1:0] decay_period_q;
  reg_e               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_count_q    <= VarW'(1024);
      decay_factor_q <= FactorW'(62259);
      bump_growth_q  <= GrowW'(68985);
      decay_period_q <= PeriodW'(100);
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_VAR_COUNT:    var_count_q    <= pwdata[VarW-1:0];
        REG_DECAY_FACTOR: decay_factor_q <= pwdata[FactorW-1:0];
        REG_BUMP_GROWTH:  bump_growth_q  <= pwdata[GrowW-1:0];
        REG_DECAY_PERIOD: decay_period_q <= pwdata[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_VAR_COUNT:    prdata = {21'd0, var_count_q};
      REG_DECAY_FACTOR: prdata = {16'd0, decay_factor_q};
      REG_BUMP_GROWTH:  prdata = {15'd0, bump_growth_q};
      REG_DECAY_PERIOD: prdata = {22'd0, decay_period_q};
      default:          prdata = '0;
    endcase
  end

  // Score memory: positive and negative score of one variable in one row.
  logic [2*SCORE_BITS-1:0] mem [NUM_VARS];
  logic [2*SCORE_BITS-1:0] rd_q;
  logic [AW-1:0]           addr;
  logic                    we;
  logic [2*SCORE_BITS-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    rd_q <= mem[addr];
  end

  state_e state_q, state_d;
  req_t   cur_q;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] limit;
  logic [SCORE_BITS-1:0] bump_q, bump_d;
  logic [PeriodW-1:0] ccnt_q, ccnt_d;
  logic [SCORE_BITS-1:0] best_q, best_d;
  logic [VarW-1:0] bvar_q, bvar_d;
  logic bneg_q, bneg_d, have_q, have_d;
  logic half_q, half_d;
  logic [SCORE_BITS+16:0] acc_q, acc_d;
  rsp_t rsp_q, rsp_d;

  // Assignment flags live in a small memory of their own. The clearing pass marks
  // every variable unassigned; a pick reads the flag beside the score row.
  logic          asg_mem [NUM_VARS];
  logic          asg_rd_q;
  logic          asg_we;
  logic          asg_wdata;
  logic [AW-1:0] asg_waddr;

  always_ff @(posedge clk_i) begin
    if (asg_we) asg_mem[asg_waddr] <= asg_wdata;
    asg_rd_q <= asg_mem[addr];
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      asg_we    = 1'b1;
      asg_waddr = idx_q[AW-1:0];
      asg_wdata = 1'b0;
    end else begin
      asg_we    = (state_q == ST_IDLE) && req.valid &&
                  req.data.req_type == REQ_ASSIGN && req.data.variable >= 1 &&
                  {21'd0, req.data.variable} <= 32'(NUM_VARS);
      asg_waddr = AW'(req.data.variable - 1'b1);
      asg_wdata = req.data.is_assigned;
    end
  end

  // Literal decode.
  logic lit_neg;
  logic [LitW:0] mag;
  logic lit_ok;
  assign lit_neg = cur_q.literal[LitW-1];
  assign mag     = lit_neg ? (LitW+1)'(13'h1000 - {1'b0, cur_q.literal})
                           : {1'b0, cur_q.literal};
  assign lit_ok  = (mag >= 1) && ({{(32-LitW-1){1'b0}}, mag} <= 32'(NUM_VARS));

  assign limit = ({21'd0, var_count_q} > 32'(NUM_VARS)) ? CW'(NUM_VARS)
                                                       : CW'(var_count_q);

  // Shared multiplier operands.
  logic [63:0] mop;
  logic [31:0] ma;
  logic [16:0] mb;
  logic [48:0] mp;
  logic        sel_neg;
  vst_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(mp));

  // High partial product shifted up by 16 plus the stored low partial product.
  logic [65:0] psum;
  assign psum = 66'({mp, 16'd0}) + 66'(acc_q);

  logic [SCORE_BITS-1:0] pos_s, neg_s, cur_s;
  assign pos_s = rd_q[SCORE_BITS-1:0];
  assign neg_s = rd_q[2*SCORE_BITS-1:SCORE_BITS];
  assign cur_s = sel_neg ? neg_s : pos_s;

  // Saturating bump add.
  logic [SCORE_BITS:0] bsum;
  logic [SCORE_BITS-1:0] bsat;
  assign bsum = {1'b0, lit_neg ? neg_s : pos_s} + {1'b0, bump_q};
  assign bsat = bsum[SCORE_BITS] ? SMax : bsum[SCORE_BITS-1:0];

  logic [PeriodW-1:0] cinc;
  assign cinc = ccnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
      bump_q  <= SCORE_BITS'(65536);
      ccnt_q  <= '0;
      have_q  <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      bump_q  <= bump_d;
      ccnt_q  <= ccnt_d;
      have_q  <= have_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) cur_q <= req.data;
    best_q <= best_d;
    bvar_q <= bvar_d;
    bneg_q <= bneg_d;
    acc_q  <= acc_d;
    rsp_q  <= rsp_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (idx_q == CW'(NUM_VARS - 1)) state_d = ST_IDLE;
      ST_IDLE: if (req.valid) begin
        unique case (req.data.req_type)
          REQ_BUMP: state_d = ST_BUMP_RD;
          REQ_PICK: state_d = (limit == 0) ? ST_OUT : ST_PICK_RD;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_BUMP_RD:  state_d = ST_BUMP_WR;
      ST_BUMP_WR:  state_d = cur_q.clause_end ? ST_GROW_LO : ST_IDLE;
      ST_GROW_LO:  state_d = ST_GROW_HI;
      ST_GROW_HI:  state_d = ST_GROW_SUM;
      ST_GROW_SUM: state_d = (cinc >= decay_period_q || cinc == 0) ? ST_DEC_RD : ST_IDLE;
      ST_DEC_RD:   state_d = ST_DEC_LO;
      ST_DEC_LO:   state_d = ST_DEC_HI;
      ST_DEC_HI:   state_d = half_q ? ST_DEC_WR : ST_DEC_LO;
      ST_DEC_WR:   state_d = (idx_q == CW'(NUM_VARS - 1)) ? ST_IDLE : ST_DEC_RD;
      ST_PICK_RD:  state_d = ST_PICK_CMP;
      ST_PICK_CMP: state_d = (idx_q + 1'b1 == limit) ? ST_OUT : ST_PICK_RD;
      ST_OUT:      if (rsp.ready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    idx_d   = idx_q;
    bump_d  = bump_q;
    ccnt_d  = ccnt_q;
    best_d  = best_q;
    bvar_d  = bvar_q;
    bneg_d  = bneg_q;
    have_d  = have_q;
    half_d  = half_q;
    acc_d   = acc_q;
    rsp_d   = rsp_q;
    we      = 1'b0;
    addr    = idx_q[AW-1:0];
    wdata   = rd_q;
    sel_neg = half_q;
    mop     = 64'(bump_q);
    ma      = mop[31:0];
    mb      = bump_growth_q;
    req.ready = (state_q == ST_IDLE);
    rsp.valid = (state_q == ST_OUT);
    rsp.data  = rsp_q;
    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        wdata = '0;
        idx_d = (idx_q == CW'(NUM_VARS - 1)) ? '0 : idx_q + 1'b1;
      end
      ST_IDLE: begin
        idx_d  = '0;
        have_d = 1'b0;
        best_d = '0;
        bvar_d = '0;
        bneg_d = 1'b0;
        rsp_d  = '0;
      end
      ST_BUMP_RD: addr = AW'(mag - 1'b1);
      ST_BUMP_WR: begin
        addr = AW'(mag - 1'b1);
        we = lit_ok;
        wdata = lit_neg ? {bsat, pos_s} : {neg_s, bsat};
      end
      ST_GROW_LO: begin
        ma = mop[31:0];
      end
      ST_GROW_HI: begin
        ma = 32'(mop[63:32]);
        acc_d = (SCORE_BITS+17)'(mp >> FracW);
      end
      ST_GROW_SUM: begin
        if (psum > 66'(SMax))
          bump_d = SMax;
        else
          bump_d = psum[SCORE_BITS-1:0];
        ccnt_d = (cinc >= decay_period_q || cinc == 0) ? '0 : cinc;
        idx_d  = '0;
        half_d = 1'b0;
      end
      ST_DEC_RD: ;
      ST_DEC_LO: begin
        mop = 64'(cur_s);
        ma  = mop[31:0];
        mb  = {1'b0, decay_factor_q};
      end
      ST_DEC_HI: begin
        mop = 64'(cur_s);
        ma  = mop[63:32];
        mb  = {1'b0, decay_factor_q};
        acc_d = (SCORE_BITS+17)'(mp >> FracW);
      end
      ST_DEC_WR: ;
      ST_PICK_RD: ;
      ST_PICK_CMP: begin
        if (!asg_rd_q) begin
          if (!have_q || pos_s > best_q) begin
            best_d = pos_s;
            bvar_d = VarW'(idx_q + 1'b1);
            bneg_d = 1'b0;
            have_d = 1'b1;
            if (neg_s > pos_s) begin
              best_d = neg_s;
              bneg_d = 1'b1;
            end
          end else if (neg_s > best_q) begin
            best_d = neg_s;
            bvar_d = VarW'(idx_q + 1'b1);
            bneg_d = 1'b1;
            have_d = 1'b1;
          end
        end
        idx_d = idx_q + 1'b1;
      end
      ST_OUT: begin
        rsp.data.found = have_q;
        rsp.data.chosen_literal = !have_q ? '0 :
          bneg_q ? LitW'(12'd0 - LitW'(bvar_q)) : LitW'(bvar_q);
      end
      default: ;
    endcase
    // Decay write-back: the HI product arrives while in ST_DEC_WR or the next LO.
    if (state_q == ST_DEC_LO && half_q) begin
      mop = 64'(neg_s);
      ma  = mop[31:0];
      mb  = {1'b0, decay_factor_q};
      // finish positive half
      wdata = {neg_s, psum[SCORE_BITS-1:0]};
    end
    if (state_q == ST_DEC_HI) half_d = ~half_q;
    if (state_q == ST_DEC_LO && half_q) we = 1'b0;
    if (state_q == ST_DEC_WR) begin
      // Both halves are done: low word already stored in best_q.
      we    = 1'b1;
      wdata = {psum[SCORE_BITS-1:0], best_q};
      idx_d = idx_q + 1'b1;
      half_d = 1'b0;
    end
    if (state_q == ST_DEC_LO && half_q)
      best_d = psum[SCORE_BITS-1:0];
  end

endmodule

/* verif/vst_checker.sv */
module vst_checker
  import vst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  vst_req_if          req,
  vst_rsp_if          rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NVARS = 1024;
  localparam logic [47:0] SCORE_MAX = '1;

  logic [47:0]        pos_act [NVARS];
  logic [47:0]        neg_act [NVARS];
  bit                 taken [NVARS];
  logic [47:0]        bump_amt;
  logic [9:0]         clauses_seen;
  logic [VarW-1:0]    var_count;
  logic [FactorW-1:0] decay_factor;
  logic [GrowW-1:0]   bump_growth;
  logic [PeriodW-1:0] decay_period;
  rsp_t               picks_due[$];

  function automatic logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = a + b;
    return s[48] ? SCORE_MAX : s[47:0];
  endfunction

  // Fixed-point scale with 16 fraction bits, truncated, clipped at the top.
  function automatic logic [47:0] scale(logic [47:0] x, logic [16:0] f);
    logic [79:0] p;
    p = x * f;
    p = p >> FracW;
    return (p > SCORE_MAX) ? SCORE_MAX : p[47:0];
  endfunction

  task automatic apply_bump(req_t w);
    logic [11:0] raw;
    logic [12:0] mag;
    bit          neg;
    raw = w.literal;
    neg = raw[11];
    mag = neg ? 13'(13'h1000 - raw) : {1'b0, raw};
    if (mag >= 1 && mag <= NVARS) begin
      if (neg) neg_act[mag-1] = sat_sum(neg_act[mag-1], bump_amt);
      else pos_act[mag-1] = sat_sum(pos_act[mag-1], bump_amt);
    end
    if (w.clause_end) begin
      bump_amt = scale(bump_amt, bump_growth);
      clauses_seen = clauses_seen + 1'b1;
      // A period of zero, or one already passed, decays at this clause end.
      if (clauses_seen >= decay_period || clauses_seen == 0) begin
        clauses_seen = '0;
        for (int i = 0; i < NVARS; i++) begin
          pos_act[i] = scale(pos_act[i], {1'b0, decay_factor});
          neg_act[i] = scale(neg_act[i], {1'b0, decay_factor});
        end
      end
    end
  endtask

  function automatic rsp_t best_literal();
    int          lim;
    int          best_var;
    bit          have;
    bit          best_neg;
    logic [47:0] best;
    rsp_t        r;
    lim = (var_count > NVARS) ? NVARS : var_count;
    have = 0;
    best_neg = 0;
    best_var = 0;
    best = '0;
    for (int v = 1; v <= lim; v++) begin
      if (!taken[v-1]) begin
        if (!have || pos_act[v-1] > best) begin
          have = 1;
          best = pos_act[v-1];
          best_var = v;
          best_neg = 0;
        end
        if (neg_act[v-1] > best) begin
          best = neg_act[v-1];
          best_var = v;
          best_neg = 1;
        end
      end
    end
    r.found = have;
    r.chosen_literal = !have ? '0 : best_neg ? 12'(-best_var) : 12'(best_var);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NVARS; i++) begin
        pos_act[i] = '0;
        neg_act[i] = '0;
        taken[i] = 0;
      end
      bump_amt = 48'd65536;
      clauses_seen = '0;
      var_count = 11'd1024;
      decay_factor = 16'd62259;
      bump_growth = 17'd68985;
      decay_period = 10'd100;
      picks_due.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[3:2]))
          REG_VAR_COUNT:    var_count = pwdata[VarW-1:0];
          REG_DECAY_FACTOR: decay_factor = pwdata[FactorW-1:0];
          REG_BUMP_GROWTH:  bump_growth = pwdata[GrowW-1:0];
          REG_DECAY_PERIOD: decay_period = pwdata[PeriodW-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (picks_due.size() == 0) begin
          $error("unexpected result word: chosen_literal %0d found %0d",
                 rsp.data.chosen_literal, rsp.data.found);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = picks_due.pop_front();
          if (rsp.data.chosen_literal !== want.chosen_literal ||
              rsp.data.found !== want.found) begin
            if (rsp.data.chosen_literal !== want.chosen_literal)
              $error("chosen_literal: expected %0d actual %0d",
                     want.chosen_literal, rsp.data.chosen_literal);
            if (rsp.data.found !== want.found)
              $error("found: expected %0d actual %0d", want.found, rsp.data.found);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (req.valid && req.ready) begin
        case (req_e'(req.data.req_type))
          REQ_BUMP: apply_bump(req.data);
          REQ_ASSIGN:
            if (req.data.variable >= 1 && req.data.variable <= NVARS)
              taken[req.data.variable-1] = req.data.is_assigned;
          REQ_PICK: picks_due.push_back(best_literal());
          default: ;
        endcase
      end
      pending_o <= picks_due.size();
    end
  end

endmodule

/* verif/tb.sv */
module tb;
  import vst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // A decay reads, rescales and writes back every score row, so the block can stay
  // busy this long after a word that gives no result.
  localparam int SETTLE = 7000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cur_vc;
  bit          calm;
  bit          hold_rsp;

  vst_req_if req_ch ();
  vst_rsp_if rsp_ch ();

  vsids_score_table dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // The checker watches both channels and the register port on its own.
  vst_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard limit, far above the slowest correct run.
  initial begin
    #100ms;
    $display("vsids_score_table verification failed");
    $finish;
  end

  // The result side takes words with random stalls. When asked, it holds off for a
  // long stretch so that the block holds its result and stops accepting requests.
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_rsp = 0;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 13);
      end
    end
  end

  // Offers one word and returns after the edge that accepted it. The valid stays
  // high for a following word unless the sender decides to idle.
  task automatic send_word(req_t w);
    req_ch.valid <= 1'b1;
    req_ch.data <= w;
    do @(posedge clk_i); while (!req_ch.ready);
    if (!calm && $urandom_range(99) < 13) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_op(req_e op, int lit, bit ce, int var_num, bit asg);
    req_t w;
    w.req_type = op;
    w.literal = 12'(lit);
    w.clause_end = ce;
    w.variable = 11'(var_num);
    w.is_assigned = asg;
    send_word(w);
  endtask

  // Waits until every pick has been answered and the block has finished any decay.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // A register write: setup cycle, then the access cycle in which it lands.
  task automatic reg_write(reg_e idx, int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(int vc, int df, int bg, int dp);
    reg_write(REG_VAR_COUNT, vc);
    reg_write(REG_DECAY_FACTOR, df);
    reg_write(REG_BUMP_GROWTH, bg);
    reg_write(REG_DECAY_PERIOD, dp);
    cur_vc = vc;
  endtask

  // Mostly literals and variables inside the scanned range, so that bumps and
  // assignments steer the picks; now and then any bit pattern at all.
  function automatic req_t random_word();
    req_t w;
    int   r;
    int   lim;
    int   mag;
    lim = (cur_vc < 1) ? 1 : (cur_vc > 1024) ? 1024 : cur_vc;
    w = req_t'(($bits(req_t))'($urandom));
    r = $urandom_range(99);
    if (r < 45) begin
      w.req_type = REQ_BUMP;
      if ($urandom_range(9) != 0) begin
        mag = $urandom_range(1, lim);
        w.literal = $urandom_range(1) ? 12'(-mag) : 12'(mag);
      end
      w.clause_end = ($urandom_range(99) < 30);
    end else if (r < 70) begin
      w.req_type = REQ_ASSIGN;
      if ($urandom_range(9) != 0) w.variable = 11'($urandom_range(1, lim));
      w.is_assigned = ($urandom_range(99) < 45);
    end else if (r < 95) begin
      w.req_type = REQ_PICK;
    end else begin
      w.req_type = REQ_NONE;
    end
    return w;
  endfunction

  initial begin
    int vc;
    int df;
    int bg;
    int dp;
    rst_ni = 1'b0;
    calm = 0;
    hold_rsp = 0;
    cur_vc = 1024;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset settings. With all scores zero the first
    // variable wins on the positive side.
    send_op(REQ_PICK, 0, 0, 0, 0);
    send_op(REQ_BUMP, 5, 0, 0, 0);
    send_op(REQ_BUMP, -7, 0, 0, 0);
    send_op(REQ_BUMP, 1024, 0, 0, 0);
    send_op(REQ_BUMP, -1024, 1, 0, 0);
    // Literals outside the table bump nothing; those with a clause end still end it.
    send_op(REQ_BUMP, 0, 1, 0, 0);
    send_op(REQ_BUMP, -2048, 0, 0, 0);
    send_op(REQ_BUMP, 2047, 1, 0, 0);
    send_op(REQ_PICK, 0, 0, 0, 0);
    send_op(REQ_ASSIGN, 0, 0, 1024, 1);
    send_op(REQ_ASSIGN, 0, 0, 0, 1);
    send_op(REQ_ASSIGN, 0, 0, 2047, 1);
    send_op(REQ_PICK, 0, 0, 0, 0);
    send_op(REQ_NONE, 3, 1, 3, 1);
    // Equal scores on both sides of one variable: the positive side wins.
    send_op(REQ_BUMP, -3, 0, 0, 0);
    send_op(REQ_BUMP, 3, 0, 0, 0);
    send_op(REQ_PICK, 0, 0, 0, 0);
    settle();

    // One variable only, a period of zero and the extreme factors.
    configure(1, 1, 131071, 0);
    send_op(REQ_ASSIGN, 0, 0, 1, 1);
    send_op(REQ_PICK, 0, 0, 0, 0);
    send_op(REQ_BUMP, 1, 1, 0, 0);
    send_op(REQ_ASSIGN, 0, 0, 1, 0);
    send_op(REQ_PICK, 0, 0, 0, 0);
    settle();
    reg_write(REG_VAR_COUNT, 0);
    send_op(REQ_PICK, 0, 0, 0, 0);
    settle();
    reg_write(REG_VAR_COUNT, 2047);
    send_op(REQ_PICK, 0, 0, 0, 0);
    settle();

    // Random phases, each under its own register setting.
    for (int p = 0; p < 7; p++) begin
      vc = (p == 2) ? 1024 : (p == 5) ? 2047 : $urandom_range(2, 48);
      df = (p == 0) ? 65535 : (p == 3) ? 1 : $urandom_range(0, 65535);
      bg = (p == 1) ? 131071 : (p == 4) ? 65536 : $urandom_range(0, 131071);
      dp = (p == 1) ? 1023 : (p == 2) ? 1 : $urandom_range(0, 20);
      configure(vc, df, bg, dp);
      calm = (p == 4);
      for (int n = 0; n < 83; n++) begin
        if (p == 3 && n == 10) begin
          hold_rsp = 1;
          repeat (6) send_op(REQ_PICK, 0, 0, 0, 0);
        end
        if (p == 6 && n == 40) begin
          // The sender pauses here until every pick so far has been answered.
          req_ch.valid <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        send_word(random_word());
      end
      calm = 0;
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("vsids_score_table verification clean");
    end else begin
      $display("vsids_score_table verification failed");
    end
    $finish;
  end

endmodule
